@@ rtl/core/lscpe_pkg.sv @@
package lscpe_pkg;

   localparam int STRIP_LEDS  = 32;
   localparam int PULSE_SLOTS = 8;
   localparam int NUM_REGIONS = 5;

   localparam int LED_AW  = (STRIP_LEDS > 1) ? $clog2(STRIP_LEDS) : 1;
   localparam int LED_CW  = $clog2(STRIP_LEDS + 1);
   localparam int SLOT_AW = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
   localparam int SLOT_CW = $clog2(PULSE_SLOTS + 1);

   localparam int SIZE_W     = 7;
   localparam int FADE_W     = 8;
   localparam int SUM_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION4 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE    = 3'd5;

   localparam logic [2:0] REGION_ALL = 3'd5;

   localparam logic ACT_TRIGGER = 1'b0;
   localparam logic ACT_FRAME   = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd6;
   localparam logic [FADE_W-1:0] FADE_RESET = 8'd215;

   typedef logic [23:0] rgb_type;

   typedef struct packed {
      logic        action;
      logic [2:0]  region;
      logic [7:0]  pulse_red;
      logic [7:0]  pulse_green;
      logic [7:0]  pulse_blue;
      logic [15:0] speed;
   } req_type;

   typedef struct packed {
      logic [5:0] led_index;
      logic [7:0] led_red;
      logic [7:0] led_green;
      logic [7:0] led_blue;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]       position;
      logic [15:0]       speed;
      logic [LED_CW-1:0] seg_start;
      logic [LED_CW-1:0] seg_stop;
      rgb_type           color;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FADE,
      ST_SLOT_RD,
      ST_SLOT_EVAL,
      ST_SLOT_PAINT,
      ST_EMIT
   } state_type;

   function automatic logic [7:0] fade8(input logic [7:0] c, input logic [7:0] f);
      logic [15:0] p;
      p = 16'(c) * 16'(f);
      return p[15:8];
   endfunction

   function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = 9'(a) + 9'(b);
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   function automatic rgb_type fade_rgb(input rgb_type c, input logic [7:0] f);
      return {fade8(c[23:16], f), fade8(c[15:8], f), fade8(c[7:0], f)};
   endfunction

   function automatic rgb_type sat_rgb(input rgb_type a, input rgb_type b);
      return {sat_add8(a[23:16], b[23:16]), sat_add8(a[15:8], b[15:8]),
              sat_add8(a[7:0], b[7:0])};
   endfunction

endpackage

@@ rtl/core/led_strip_comet_pulse_engine.sv @@
// LED strip comet pulse engine.
//
// Requests arrive on req_* (valid/ready). A trigger request (action 0) claims
// the first free pulse slot and produces no response; a region above the
// whole-strip code, or a full slot table, drops the request. A frame request
// (action 1) fades the strip, advances every active pulse and paints those
// inside their segment, then streams one response per LED on rsp_* with last
// set on the final LED. Region sizes and the fade factor are written through
// csr_*; the user must write them only while idle, as the block itself does
// not enforce it.
//
// A frame runs a fade sweep through the LED memory read port, a walk over
// the slots (read-modify-write of one LED per slot that paints), then the
// emit stream at one LED per cycle when rsp_ready stays high. The last LED
// sits in the output register while the next request is taken; a stalled
// receiver holds the emit stream in place.
//
// Reset clears the pulse table and sweeps zeros through the LED memory, one
// entry per cycle, before req_ready rises.
module led_strip_comet_pulse_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lscpe_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lscpe_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [lscpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lscpe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import lscpe_pkg::*;

   // control state
   state_type               state_ff, state_in;
   logic [LED_CW-1:0]       step_cnt_ff, step_cnt_in;
   logic [SLOT_CW-1:0]      slot_cnt_ff, slot_cnt_in;
   logic [PULSE_SLOTS-1:0]  slot_active_ff, slot_active_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [LED_AW-1:0]       rd_idx_ff, rd_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [LED_AW-1:0]       paint_addr_ff, paint_addr_in;
   rgb_type                 paint_color_ff, paint_color_in;

   // configuration
   logic [SIZE_W-1:0]       region_size_ff [NUM_REGIONS];
   logic [FADE_W-1:0]       fade_ff;

   // LED memory port
   logic                    led_wr_en, led_rd_en;
   logic [LED_AW-1:0]       led_wr_addr, led_rd_addr;
   rgb_type                 led_wr_data, led_rd_data;

   // slot memory port
   logic                    slot_wr_en, slot_rd_en;
   logic [SLOT_AW-1:0]      slot_wr_addr, slot_rd_addr;
   slot_type                slot_wr_data, slot_q;
   logic [$bits(slot_type)-1:0] slot_rd_bits;

   // trigger decode
   logic                    accept;
   logic [SUM_W-1:0]        start_raw, stop_raw;
   logic [SIZE_W-1:0]       sel_size;
   logic [LED_CW-1:0]       trig_start, trig_stop;
   logic                    free_found;
   logic [SLOT_AW-1:0]      free_idx;
   logic                    trig_we;
   slot_type                trig_rec;

   // slot evaluation
   logic [SLOT_AW-1:0]      slot_sel;
   logic [15:0]             pos_new;
   logic [7:0]              head;
   logic                    hit, retire;

   // emit stream
   logic                    emit_load, emit_issue;
   logic [LED_CW-1:0]       fade_wr_cnt;

   lscpe_ram #(
      .WIDTH ($bits(rgb_type)),
      .DEPTH (STRIP_LEDS)
   ) u_led_ram (
      .clock   (clock),
      .wr_en   (led_wr_en),
      .wr_addr (led_wr_addr),
      .wr_data (led_wr_data),
      .rd_en   (led_rd_en),
      .rd_addr (led_rd_addr),
      .rd_data (led_rd_data)
   );

   lscpe_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (PULSE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_bits)
   );

   assign slot_q    = slot_rd_bits;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_sel  = slot_cnt_ff[SLOT_AW-1:0];

   // configuration writes, accepted in any state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGIONS; k++) begin
            region_size_ff[k] <= SIZE_RESET;
         end
         fade_ff <= FADE_RESET;
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_REGION0, CSR_REGION1, CSR_REGION2, CSR_REGION3, CSR_REGION4: begin
               region_size_ff[csr_index] <= csr_wdata[SIZE_W-1:0];
            end
            CSR_FADE: begin
               fade_ff <= csr_wdata[FADE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // region bounds: whole strip, or prefix sum of sizes below the region, clamped
   always_comb begin
      start_raw = '0;
      sel_size  = '0;
      for (int k = 0; k < NUM_REGIONS; k++) begin
         if (3'(k) < req_data.region) begin
            start_raw = start_raw + SUM_W'(region_size_ff[k]);
         end
         if (3'(k) == req_data.region) begin
            sel_size = region_size_ff[k];
         end
      end
      stop_raw = start_raw + SUM_W'(sel_size);
      if (req_data.region == REGION_ALL) begin
         trig_start = '0;
         trig_stop  = LED_CW'(STRIP_LEDS);
      end else begin
         trig_start = (start_raw > SUM_W'(STRIP_LEDS)) ? LED_CW'(STRIP_LEDS)
                                                       : LED_CW'(start_raw);
         trig_stop  = (stop_raw > SUM_W'(STRIP_LEDS)) ? LED_CW'(STRIP_LEDS)
                                                      : LED_CW'(stop_raw);
      end
   end

   // first free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = 0; s < PULSE_SLOTS; s++) begin
         if (!free_found && !slot_active_ff[s]) begin
            free_found = 1'b1;
            free_idx   = SLOT_AW'(s);
         end
      end
   end

   assign trig_we = accept && (req_data.action == ACT_TRIGGER) &&
                    (req_data.region <= REGION_ALL) && free_found;

   always_comb begin
      trig_rec.position  = {8'(trig_start), 8'h00};
      trig_rec.speed     = req_data.speed;
      trig_rec.seg_start = trig_start;
      trig_rec.seg_stop  = trig_stop;
      trig_rec.color     = {req_data.pulse_red, req_data.pulse_green, req_data.pulse_blue};
   end

   // advance the slot just read; head lands on the integer part
   assign pos_new = slot_q.position + slot_q.speed;
   assign head    = pos_new[15:8];
   assign hit     = (head >= 8'(slot_q.seg_start)) && (head < 8'(slot_q.seg_stop)) &&
                    (head < 8'(STRIP_LEDS));
   assign retire  = (head >= 8'(slot_q.seg_stop));

   // emit: load the output register from held read data, read ahead when free
   assign emit_load  = rd_pend_ff && (!rsp_valid_ff || rsp_ready);
   assign emit_issue = (state_ff == ST_EMIT) && (step_cnt_ff < LED_CW'(STRIP_LEDS)) &&
                       (!rd_pend_ff || emit_load);
   assign fade_wr_cnt = step_cnt_ff - LED_CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (step_cnt_ff == LED_CW'(STRIP_LEDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_data.action == ACT_FRAME)) begin
               state_in = ST_FADE;
            end
         end
         ST_FADE: begin
            if (step_cnt_ff == LED_CW'(STRIP_LEDS)) begin
               state_in = ST_SLOT_RD;
            end
         end
         ST_SLOT_RD: begin
            if (slot_cnt_ff == SLOT_CW'(PULSE_SLOTS)) begin
               state_in = ST_EMIT;
            end else if (slot_active_ff[slot_sel]) begin
               state_in = ST_SLOT_EVAL;
            end
         end
         ST_SLOT_EVAL: begin
            state_in = hit ? ST_SLOT_PAINT : ST_SLOT_RD;
         end
         ST_SLOT_PAINT: begin
            state_in = ST_SLOT_RD;
         end
         ST_EMIT: begin
            if (emit_load && (rd_idx_ff == LED_AW'(STRIP_LEDS - 1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // counters, slot flags and output register
   always_comb begin
      step_cnt_in    = step_cnt_ff;
      slot_cnt_in    = slot_cnt_ff;
      slot_active_in = slot_active_ff;
      rd_pend_in     = rd_pend_ff;
      rd_idx_in      = rd_idx_ff;
      paint_addr_in  = paint_addr_ff;
      paint_color_in = paint_color_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            step_cnt_in = (step_cnt_ff == LED_CW'(STRIP_LEDS - 1)) ? '0
                                                                  : step_cnt_ff + LED_CW'(1);
         end
         ST_IDLE: begin
            step_cnt_in = '0;
            slot_cnt_in = '0;
            if (trig_we) begin
               slot_active_in[free_idx] = 1'b1;
            end
         end
         ST_FADE: begin
            if (step_cnt_ff != LED_CW'(STRIP_LEDS)) begin
               step_cnt_in = step_cnt_ff + LED_CW'(1);
            end
         end
         ST_SLOT_RD: begin
            if (slot_cnt_ff == SLOT_CW'(PULSE_SLOTS)) begin
               step_cnt_in = '0;
               rd_pend_in  = 1'b0;
            end else if (!slot_active_ff[slot_sel]) begin
               slot_cnt_in = slot_cnt_ff + SLOT_CW'(1);
            end
         end
         ST_SLOT_EVAL: begin
            if (retire) begin
               slot_active_in[slot_sel] = 1'b0;
            end
            if (hit) begin
               paint_addr_in  = head[LED_AW-1:0];
               paint_color_in = slot_q.color;
            end else begin
               slot_cnt_in = slot_cnt_ff + SLOT_CW'(1);
            end
         end
         ST_SLOT_PAINT: begin
            slot_cnt_in = slot_cnt_ff + SLOT_CW'(1);
         end
         ST_EMIT: begin
            if (emit_issue) begin
               step_cnt_in = step_cnt_ff + LED_CW'(1);
               rd_idx_in   = step_cnt_ff[LED_AW-1:0];
               rd_pend_in  = 1'b1;
            end else if (emit_load) begin
               rd_pend_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // the output register drains in any state
      if (emit_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.led_index = 6'(rd_idx_ff);
         rsp_data_in.led_red   = led_rd_data[23:16];
         rsp_data_in.led_green = led_rd_data[15:8];
         rsp_data_in.led_blue  = led_rd_data[7:0];
         rsp_data_in.last      = (rd_idx_ff == LED_AW'(STRIP_LEDS - 1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // memory controls and handshake outputs
   always_comb begin
      req_ready    = 1'b0;
      led_wr_en    = 1'b0;
      led_wr_addr  = step_cnt_ff[LED_AW-1:0];
      led_wr_data  = '0;
      led_rd_en    = 1'b0;
      led_rd_addr  = step_cnt_ff[LED_AW-1:0];
      slot_wr_en   = 1'b0;
      slot_wr_addr = slot_sel;
      slot_wr_data = trig_rec;
      slot_rd_en   = 1'b0;
      slot_rd_addr = slot_sel;

      unique case (state_ff)
         ST_CLEAR: begin
            led_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            slot_wr_en   = trig_we;
            slot_wr_addr = free_idx;
         end
         ST_FADE: begin
            led_rd_en   = (step_cnt_ff != LED_CW'(STRIP_LEDS));
            led_wr_en   = (step_cnt_ff != '0);
            led_wr_addr = fade_wr_cnt[LED_AW-1:0];
            led_wr_data = fade_rgb(led_rd_data, fade_ff);
         end
         ST_SLOT_RD: begin
            slot_rd_en = (slot_cnt_ff != SLOT_CW'(PULSE_SLOTS)) && slot_active_ff[slot_sel];
         end
         ST_SLOT_EVAL: begin
            slot_wr_en            = 1'b1;
            slot_wr_data          = slot_q;
            slot_wr_data.position = pos_new;
            led_rd_en             = hit;
            led_rd_addr           = head[LED_AW-1:0];
         end
         ST_SLOT_PAINT: begin
            led_wr_en   = 1'b1;
            led_wr_addr = paint_addr_ff;
            led_wr_data = sat_rgb(led_rd_data, paint_color_ff);
         end
         ST_EMIT: begin
            led_rd_en = emit_issue;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         step_cnt_ff    <= '0;
         slot_cnt_ff    <= '0;
         slot_active_ff <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_cnt_ff    <= step_cnt_in;
         slot_cnt_ff    <= slot_cnt_in;
         slot_active_ff <= slot_active_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      rsp_data_ff    <= rsp_data_in;
      paint_addr_ff  <= paint_addr_in;
      paint_color_ff <= paint_color_in;
   end

endmodule

@@ rtl/core/lscpe_ram.sv @@
module lscpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // registered read; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ tb/sv/lscpe_tb_pkg.sv @@
`timescale 1ns / 100ps

package lscpe_tb_pkg;

   import lscpe_pkg::*;

   typedef logic [SIZE_W-1:0] region_sizes_type [NUM_REGIONS];

   class strip_frame_tracker;

      logic [SIZE_W-1:0] region_len [NUM_REGIONS];
      logic [FADE_W-1:0] fade;
      rgb_type           leds [STRIP_LEDS];
      bit                busy [PULSE_SLOTS];
      logic [15:0]       pos  [PULSE_SLOTS];
      logic [15:0]       pace [PULSE_SLOTS];
      int                lo   [PULSE_SLOTS];
      int                hi   [PULSE_SLOTS];
      rgb_type           tint [PULSE_SLOTS];
      rsp_type           pending_leds [$];
      int                failures;

      function new();
         foreach (region_len[k]) region_len[k] = SIZE_RESET;
         fade = FADE_RESET;
         foreach (leds[i]) leds[i] = '0;
         foreach (busy[s]) busy[s] = 1'b0;
         failures = 0;
      endfunction

      function void write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_FADE)
            fade = val[FADE_W-1:0];
         else if (idx < CSR_FADE)
            region_len[idx] = val[SIZE_W-1:0];
      endfunction

      function logic [7:0] dim(logic [7:0] c);
         int p;
         p = int'(c) * int'(fade);
         return 8'(p >> 8);
      endfunction

      function logic [7:0] brighten(logic [7:0] a, logic [7:0] b);
         int s;
         s = int'(a) + int'(b);
         return (s > 255) ? 8'hFF : 8'(s);
      endfunction

      // Claim the first free slot; out-of-range regions and a full table drop it.
      function void start_pulse(req_type r);
         int first;
         int stop;
         if (r.region > REGION_ALL) return;
         first = 0;
         if (r.region == REGION_ALL) begin
            stop = STRIP_LEDS;
         end else begin
            for (int k = 0; k < int'(r.region); k++) first += region_len[k];
            stop  = first + region_len[r.region];
            stop  = (stop > STRIP_LEDS) ? STRIP_LEDS : stop;
            first = (first > STRIP_LEDS) ? STRIP_LEDS : first;
         end
         for (int s = 0; s < PULSE_SLOTS; s++) begin
            if (!busy[s]) begin
               busy[s] = 1'b1;
               pos[s]  = 16'(first << 8);
               pace[s] = r.speed;
               lo[s]   = first;
               hi[s]   = stop;
               tint[s] = {r.pulse_red, r.pulse_green, r.pulse_blue};
               return;
            end
         end
      endfunction

      // Fade, advance and paint, then queue one response per LED.
      function void render_frame();
         int      head;
         rsp_type led;
         foreach (leds[i])
            leds[i] = {dim(leds[i][23:16]), dim(leds[i][15:8]), dim(leds[i][7:0])};
         for (int s = 0; s < PULSE_SLOTS; s++) begin
            if (busy[s]) begin
               pos[s] = pos[s] + pace[s];
               head   = int'(pos[s] >> 8);
               if (head >= lo[s] && head < hi[s] && head < STRIP_LEDS)
                  leds[head] = {brighten(leds[head][23:16], tint[s][23:16]),
                                brighten(leds[head][15:8], tint[s][15:8]),
                                brighten(leds[head][7:0], tint[s][7:0])};
               if (head >= hi[s]) busy[s] = 1'b0;
            end
         end
         for (int i = 0; i < STRIP_LEDS; i++) begin
            led.led_index = 6'(i);
            led.led_red   = leds[i][23:16];
            led.led_green = leds[i][15:8];
            led.led_blue  = leds[i][7:0];
            led.last      = (i == STRIP_LEDS - 1);
            pending_leds.push_back(led);
         end
      endfunction

      function void note_request(req_type r);
         if (r.action == ACT_FRAME)
            render_frame();
         else
            start_pulse(r);
      endfunction

      function void flag(string field, logic [7:0] want, logic [7:0] got);
         failures++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_led(rsp_type got);
         rsp_type want;
         if (pending_leds.size() == 0) begin
            failures++;
            $display("%0t: unexpected response: expected none, got index %0d rgb %h_%h_%h last %b",
                     $time, got.led_index, got.led_red, got.led_green, got.led_blue, got.last);
            return;
         end
         want = pending_leds.pop_front();
         if (got.led_index !== want.led_index)
            flag("led_index", 8'(want.led_index), 8'(got.led_index));
         if (got.led_red !== want.led_red) flag("led_red", want.led_red, got.led_red);
         if (got.led_green !== want.led_green) flag("led_green", want.led_green, got.led_green);
         if (got.led_blue !== want.led_blue) flag("led_blue", want.led_blue, got.led_blue);
         if (got.last !== want.last) flag("last", 8'(want.last), 8'(got.last));
      endfunction

   endclass

endpackage

@@ tb/sv/tb_led_strip_comet_pulse_engine.sv @@
`timescale 1ns / 100ps

module tb_led_strip_comet_pulse_engine;

   import lscpe_pkg::*;
   import lscpe_tb_pkg::*;

   // Quiet time after the last response before touching the registers or
   // ending; also covers the LED memory clear sweep after reset.
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 35;
   localparam int RANDOM_PHASES  = 8;

   localparam logic [CSR_IDX_W-1:0] SIZE_REGS [NUM_REGIONS] =
      '{CSR_REGION0, CSR_REGION1, CSR_REGION2, CSR_REGION3, CSR_REGION4};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   strip_frame_tracker tracker = new();

   int sender_pct   = 0;
   int receiver_pct = 0;
   int idle_cycles  = 0;

   led_strip_comet_pulse_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample both handshakes at the edge, check responses before feeding the
   // request taken at the same edge, then roll the next receiver stall.
   always @(posedge clock) begin
      logic moved;
      moved = 1'b0;
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_led(rsp_data);
         moved = 1'b1;
      end
      if (!reset && req_valid && req_ready) begin
         tracker.note_request(req_data);
         moved = 1'b1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      rsp_ready   <= ($urandom_range(99) >= receiver_pct);
   end

   // Give up when no handshake has happened for too long.
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Present one request, idling first at the current sender rate; return on
   // the edge that accepts it, with valid still high.
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < sender_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic fire_pulse(input logic [2:0] region, input rgb_type color,
                             input logic [15:0] speed);
      req_type r;
      r.action      = ACT_TRIGGER;
      r.region      = region;
      r.pulse_red   = color[23:16];
      r.pulse_green = color[15:8];
      r.pulse_blue  = color[7:0];
      r.speed       = speed;
      send_request(r);
   endtask

   // Fill the fields a frame ignores with noise.
   task automatic tick_frame();
      req_type r;
      r        = req_type'(44'({$urandom, $urandom}));
      r.action = ACT_FRAME;
      send_request(r);
   endtask

   // Drop valid, let the monitor note the last request, drain every expected
   // response, then hold quiet a while.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_leds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all six registers on consecutive edges; the block must be idle.
   task automatic load_settings(input region_sizes_type sizes, input logic [FADE_W-1:0] fade);
      for (int k = 0; k <= NUM_REGIONS; k++) begin
         csr_we    <= 1'b1;
         csr_index <= (k == NUM_REGIONS) ? CSR_FADE : SIZE_REGS[k];
         csr_wdata <= (k == NUM_REGIONS) ? CSR_DATA_W'(fade) : CSR_DATA_W'(sizes[k]);
         tracker.write_csr((k == NUM_REGIONS) ? CSR_FADE : SIZE_REGS[k],
                           (k == NUM_REGIONS) ? CSR_DATA_W'(fade) : CSR_DATA_W'(sizes[k]));
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly bursts of valid triggers followed by a few frames, with some
   // noise requests mixed in; dropped out-of-range triggers are not counted.
   task automatic random_phase(input int items);
      int          sent;
      int          burst;
      int          ticks;
      logic [15:0] speed;
      req_type     noise;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 15) begin
            noise = req_type'(44'({$urandom, $urandom}));
            send_request(noise);
            if (noise.action == ACT_FRAME || noise.region <= REGION_ALL) sent++;
         end else begin
            burst = $urandom_range(1, 4);
            ticks = $urandom_range(1, 3);
            repeat (burst) begin
               case ($urandom_range(9))
                  0:       speed = 16'($urandom);
                  1:       speed = 16'($urandom_range(16'hFF00, 16'hFFFF));
                  default: speed = 16'($urandom_range(16'h0040, 16'h0600));
               endcase
               fire_pulse(3'($urandom_range(0, 5)), 24'($urandom), speed);
            end
            repeat (ticks) tick_frame();
            sent += burst + ticks;
         end
      end
   endtask

   initial begin
      region_sizes_type sizes;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // Directed: one pulse per region and one on the whole strip, two
      // out-of-range regions, a full slot table, a pulse that wraps straight
      // past the region end, and one that walks backward.
      sizes = '{7'd6, 7'd6, 7'd6, 7'd6, 7'd6};
      load_settings(sizes, 8'd215);
      fire_pulse(3'd0, 24'hFF0000, 16'h0100);
      fire_pulse(3'd1, 24'h00FF00, 16'h0080);
      fire_pulse(3'd2, 24'h0000FF, 16'h0300);
      fire_pulse(3'd3, 24'hFFFFFF, 16'h0200);
      fire_pulse(3'd4, 24'h808080, 16'h0100);
      fire_pulse(REGION_ALL, 24'h010203, 16'h0040);
      fire_pulse(3'd6, 24'hFFFFFF, 16'h0100);
      fire_pulse(3'd7, 24'hFFFFFF, 16'h0100);
      fire_pulse(3'd0, 24'hFFFFFF, 16'hFFFF);
      fire_pulse(3'd2, 24'hFEFEFE, 16'h0180);
      fire_pulse(3'd1, 24'h123456, 16'h0100);
      repeat (3) tick_frame();
      fire_pulse(3'd1, 24'hFFFFFF, 16'hFFFF);
      repeat (3) tick_frame();

      // Regions past the strip end and an empty region: both clamp to the
      // strip length, paint nothing and free on the first frame.
      settle();
      sizes = '{7'd20, 7'd64, 7'd5, 7'd0, 7'd64};
      load_settings(sizes, 8'd255);
      fire_pulse(3'd2, 24'hFFFFFF, 16'h0000);
      fire_pulse(3'd3, 24'hFFFFFF, 16'h0000);
      fire_pulse(3'd1, 24'hFFFFFF, 16'h0100);
      fire_pulse(3'd0, 24'h7F7F7F, 16'h0280);
      repeat (2) tick_frame();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p % 4)
            0: begin sender_pct = 0;  receiver_pct = 0;  end
            1: begin sender_pct = 57; receiver_pct = 0;  end
            2: begin sender_pct = 0;  receiver_pct = 57; end
            default: begin sender_pct = 13; receiver_pct = 13; end
         endcase
         case (p)
            0: begin
               sizes = '{7'd6, 7'd6, 7'd6, 7'd6, 7'd6};
               load_settings(sizes, 8'd215);
            end
            1: begin
               sizes = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
               load_settings(sizes, 8'd255);
            end
            2: begin
               sizes = '{7'd64, 7'd64, 7'd64, 7'd64, 7'd64};
               load_settings(sizes, 8'd0);
            end
            default: begin
               foreach (sizes[k])
                  sizes[k] = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 7'd64 : 7'd0)
                                                      : 7'($urandom_range(0, 16));
               load_settings(sizes, 8'($urandom_range(0, 255)));
            end
         endcase
         random_phase(PHASE_ITEMS);
      end

      settle();
      if (tracker.failures == 0 && tracker.pending_leds.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/lscpe_pkg.sv
rtl/core/lscpe_ram.sv
rtl/core/led_strip_comet_pulse_engine.sv
tb/sv/lscpe_tb_pkg.sv
tb/sv/tb_led_strip_comet_pulse_engine.sv
